// File: rtl/core/nii_pkg.sv
// Shared types, constants and tables of the interval integrator.
`default_nettype none
package nii_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAND = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RULE = 1'd1;

  localparam logic [1:0] FN_IDENT = 2'd0;
  localparam logic [1:0] FN_DOUBLE = 2'd1;
  localparam logic [1:0] FN_SINE = 2'd2;

  // Evaluation point within one subinterval
  localparam logic [1:0] PT_LO = 2'd0;
  localparam logic [1:0] PT_HI = 2'd1;
  localparam logic [1:0] PT_MID = 2'd2;

  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [47:0] RES_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] RES_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic       d6_start;
    logic       take_h;
    logic       t_clear;
    logic       eval_load;
    logic [1:0] pt;
    logic       cordic_step;
    logic [4:0] cidx;
    logic       eval_acc;
    logic       s_acc;
    logic       mul_init;
    logic       mul_step;
    logic [2:0] mul_idx;
    logic       res_load;
    logic       res_div6;
    logic       res_zero;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic div_done;
    logic d6_done;
    logic sine;
    logic rule;
    logic last_sub;
    logic out_free;
  } st_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/nii_if.sv
// Request and result channel interfaces of the interval integrator.
`default_nettype none
interface nii_in_if #(parameter int unsigned COUNT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    interval_start;
  logic signed [31:0]    interval_end;
  logic [COUNT_BITS-1:0] subinterval_count;
  modport source(output valid, interval_start, interval_end, subinterval_count,
                 input ready);
  modport sink(input valid, interval_start, interval_end, subinterval_count,
               output ready);
endinterface

interface nii_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] integral;
  logic               count_error;
  modport source(output valid, integral, count_error, input ready);
  modport sink(input valid, integral, count_error, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nii_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module nii_div #(
  parameter int unsigned DW = 50,
  parameter int unsigned VW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW:0]   rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;

  assign rem_sh = {rem_r[VW-1:0], q_r[DW-1]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract where it fits
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// File: rtl/core/nii_dp.sv
// Datapath: step division, CORDIC sine, term sums, final scaling and result register.
`default_nettype none
module nii_dp #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire nii_pkg::cmd_t                 cmd,
  output nii_pkg::st_t                       st,
  input  wire logic                          cfg_we,
  input  wire logic [nii_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [nii_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic signed [31:0]            in_start,
  input  wire logic signed [31:0]            in_end,
  input  wire logic [COUNT_BITS-1:0]         in_count,
  nii_out_if.source                          out_ch
);
  localparam int unsigned DW = 50;
  // ceil(2^19 / 3): exact quotient by three for any value below 2^19
  localparam logic [18:0] D3_RECIP = 19'd174763;

  logic [1:0]            integrand_r;
  logic                  rule_r;
  logic signed [31:0]    a_r;
  logic signed [32:0]    span_r;
  logic [COUNT_BITS-1:0] n_r, k_r;
  logic signed [48:0]    h_r;
  logic signed [49:0]    pos_r;
  logic signed [31:0]    x_r;
  logic signed [33:0]    cx_r, cy_r, z_r;
  logic signed [36:0]    t_r;
  logic signed [63:0]    s_r;
  logic [63:0]           us_r, uh_r;
  logic [111:0]          prod_r;
  logic                  neg_r;
  logic                  out_valid_r;
  logic signed [47:0]    integral_r;
  logic                  err_r;
  logic [47:0]           d6_x_r, d6_q_r;
  logic [1:0]            d6_r_r, d6_cnt_r;

  // divider
  logic          div_done;
  logic [DW-1:0] div_q, div_dvd;
  logic [COUNT_BITS-1:0] div_dvs;
  logic [31:0]   span_mag;
  logic [47:0]   mag;

  assign span_mag = span_r[32] ? 32'(-span_r) : span_r[31:0];
  assign mag      = prod_r[83:36];
  assign div_dvd  = DW'({span_mag, 16'h0000});
  assign div_dvs  = n_r;

  nii_div #(.DW(DW), .VW(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // divide by six: halve, then three 16-bit digits by reciprocal multiply
  logic [48:0] mag_rnd6;
  logic [17:0] d6_v, d6_back;
  logic [36:0] d6_prod;
  logic [15:0] d6_qd;
  assign mag_rnd6 = 49'(mag) + 49'd3;
  assign d6_v     = {d6_r_r, d6_x_r[47:32]};
  assign d6_prod  = 37'(d6_v) * 37'(D3_RECIP);
  assign d6_qd    = d6_prod[34:19];
  assign d6_back  = d6_v - ({2'b00, d6_qd} + {1'b0, d6_qd, 1'b0});

  // evaluation point
  logic signed [49:0] pt_pos;
  logic signed [31:0] pt_x;
  logic signed [33:0] x_ext, z_fold;
  always_comb begin
    unique case (cmd.pt)
      nii_pkg::PT_HI:  pt_pos = pos_r + 50'(h_r);
      nii_pkg::PT_MID: pt_pos = pos_r + 50'(h_r >>> 1);
      default:         pt_pos = pos_r;
    endcase
    pt_x  = pt_pos[47:16];
    x_ext = 34'(pt_x);
    // fold beyond +-pi/2
    if (x_ext > nii_pkg::HALF_PI_Q30) begin
      z_fold = nii_pkg::PI_Q30 - x_ext;
    end else if (x_ext < -nii_pkg::HALF_PI_Q30) begin
      z_fold = -nii_pkg::PI_Q30 - x_ext;
    end else begin
      z_fold = x_ext;
    end
  end

  // one CORDIC rotation
  logic signed [33:0] dx, dy, at;
  assign dx = cy_r >>> cmd.cidx;
  assign dy = cx_r >>> cmd.cidx;
  assign at = 34'($signed({1'b0, nii_pkg::atan_q30(cmd.cidx)}));

  // function value
  logic signed [33:0] fval;
  logic signed [36:0] fterm;
  always_comb begin
    unique case (integrand_r)
      nii_pkg::FN_DOUBLE: fval = 34'(x_r) <<< 1;
      nii_pkg::FN_SINE:   fval = cy_r;
      default:            fval = 34'(x_r);
    endcase
    fterm = (cmd.pt == nii_pkg::PT_MID) ? (37'(fval) <<< 2) : 37'(fval);
  end

  // saturating running sum
  logic signed [64:0] sum_w;
  logic signed [63:0] sum_sat;
  always_comb begin
    sum_w = 65'(s_r) + 65'(t_r);
    priority if (sum_w > 65'(nii_pkg::SUM_MAX)) begin
      sum_sat = nii_pkg::SUM_MAX;
    end else if (sum_w < -65'(nii_pkg::SUM_MAX)) begin
      sum_sat = -nii_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_w[63:0];
    end
  end

  // partial product: 32-bit half of |S| times 16-bit chunk of |h|
  logic [31:0]  pp_a;
  logic [15:0]  pp_b;
  logic [47:0]  pp;
  logic [6:0]   pp_sh;
  assign pp_a  = cmd.mul_idx[0] ? us_r[63:32] : us_r[31:0];
  assign pp_b  = uh_r[16*cmd.mul_idx[2:1] +: 16];
  assign pp    = pp_a * pp_b;
  assign pp_sh = {1'b0, cmd.mul_idx[0], 5'd0} + {1'b0, cmd.mul_idx[2:1], 4'd0};

  // final rounding and saturation
  logic [48:0]        res_mag;
  logic signed [47:0] res_val;
  always_comb begin
    res_mag = cmd.res_div6 ? {1'b0, d6_q_r} : ((49'(mag) + 49'd1) >> 1);
    priority if (|prod_r[111:84]) begin
      res_val = neg_r ? nii_pkg::RES_MIN : nii_pkg::RES_MAX;
    end else if (neg_r) begin
      res_val = (res_mag > 49'h0_8000_0000_0000) ? nii_pkg::RES_MIN : -$signed(res_mag[47:0]);
    end else begin
      res_val = (res_mag > 49'h0_7FFF_FFFF_FFFF) ? nii_pkg::RES_MAX : $signed(res_mag[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integrand_r <= nii_pkg::FN_IDENT;
      rule_r      <= 1'b0;
      out_valid_r <= 1'b0;
      d6_cnt_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == nii_pkg::CFG_INTEGRAND) begin
        integrand_r <= cfg_data;
      end
      if (cfg_we && cfg_index == nii_pkg::CFG_RULE) begin
        rule_r <= cfg_data[0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.d6_start) begin
        d6_cnt_r <= 2'd3;
      end else if (d6_cnt_r != 2'd0) begin
        d6_cnt_r <= d6_cnt_r - 2'd1;
      end
    end
    if (cmd.load_in) begin
      a_r    <= in_start;
      span_r <= 33'(in_end) - 33'(in_start);
      n_r    <= in_count;
      s_r    <= '0;
    end
    if (cmd.take_h) begin
      h_r   <= span_r[32] ? -$signed(div_q[48:0]) : $signed(div_q[48:0]);
      pos_r <= 50'(a_r) <<< 16;
      k_r   <= '0;
    end
    if (cmd.t_clear) begin
      t_r <= '0;
    end
    if (cmd.eval_load) begin
      x_r  <= pt_x;
      cx_r <= nii_pkg::CORDIC_GAIN_Q30;
      cy_r <= '0;
      z_r  <= z_fold;
    end
    if (cmd.cordic_step) begin
      if (!z_r[33]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + at;
      end
    end
    if (cmd.eval_acc) begin
      t_r <= t_r + fterm;
    end
    if (cmd.s_acc) begin
      s_r   <= sum_sat;
      pos_r <= pos_r + 50'(h_r);
      k_r   <= k_r + COUNT_BITS'(1);
    end
    if (cmd.mul_init) begin
      us_r   <= s_r[63] ? 64'(-s_r) : 64'(s_r);
      uh_r   <= h_r[48] ? 64'(-h_r) : 64'(h_r);
      neg_r  <= s_r[63] != h_r[48];
      prod_r <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_r + (112'(pp) << pp_sh);
    end
    if (cmd.d6_start) begin
      d6_x_r <= mag_rnd6[48:1];
      d6_r_r <= '0;
    end else if (d6_cnt_r != 2'd0) begin
      // advance one quotient digit, carry the remainder
      d6_x_r <= {d6_x_r[31:0], 16'h0000};
      d6_q_r <= {d6_q_r[31:0], d6_qd};
      d6_r_r <= d6_back[1:0];
    end
    if (cmd.res_load) begin
      integral_r <= res_val;
      err_r      <= 1'b0;
    end
    if (cmd.res_zero) begin
      integral_r <= '0;
      err_r      <= 1'b1;
    end
  end

  assign st.n_zero   = (n_r == '0);
  assign st.div_done = div_done;
  assign st.d6_done  = (d6_cnt_r == 2'd0);
  assign st.sine     = (integrand_r == nii_pkg::FN_SINE);
  assign st.rule     = rule_r;
  assign st.last_sub = (k_r == n_r - COUNT_BITS'(1));
  assign st.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.integral    = integral_r;
  assign out_ch.count_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.count_error |-> out_ch.integral == '0)
    else $error("count error result with nonzero integral");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("result load did not raise valid");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ch.ready)
    else $error("result overwritten before taken");
endmodule
`default_nettype wire

// File: rtl/core/nii_ctrl.sv
// Controller: sequences division, point evaluations, summation and scaling.
`default_nettype none
module nii_ctrl #(
  parameter int unsigned CORDIC_STEPS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire nii_pkg::st_t st,
  output nii_pkg::cmd_t     cmd
);
  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIVH = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_EVL  = 4'd4;
  localparam logic [3:0] S_COR  = 4'd5;
  localparam logic [3:0] S_EACC = 4'd6;
  localparam logic [3:0] S_SACC = 4'd7;
  localparam logic [3:0] S_MULI = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_DIV6 = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    pt_r, pt_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [2:0]    mj_r, mj_nxt;

  always_comb begin
    state_nxt = state_r;
    pt_nxt    = pt_r;
    step_nxt  = step_r;
    mj_nxt    = mj_r;
    cmd       = '0;
    cmd.pt      = pt_r;
    cmd.cidx    = 5'(step_r);
    cmd.mul_idx = mj_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (st.n_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVH;
        end
      end
      S_DIVH: begin
        if (st.div_done) begin
          cmd.take_h = 1'b1;
          state_nxt  = S_SUB;
        end
      end
      S_SUB: begin
        cmd.t_clear = 1'b1;
        pt_nxt      = nii_pkg::PT_LO;
        state_nxt   = S_EVL;
      end
      S_EVL: begin
        cmd.eval_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = st.sine ? S_COR : S_EACC;
      end
      S_COR: begin
        cmd.cordic_step = 1'b1;
        step_nxt        = step_r + SW'(1);
        if (step_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_EACC;
        end
      end
      S_EACC: begin
        cmd.eval_acc = 1'b1;
        state_nxt    = S_EVL;
        if (pt_r == nii_pkg::PT_LO) begin
          pt_nxt = nii_pkg::PT_HI;
        end else if (pt_r == nii_pkg::PT_HI && st.rule) begin
          pt_nxt = nii_pkg::PT_MID;
        end else begin
          state_nxt = S_SACC;
        end
      end
      S_SACC: begin
        cmd.s_acc = 1'b1;
        state_nxt = st.last_sub ? S_MULI : S_SUB;
      end
      S_MULI: begin
        cmd.mul_init = 1'b1;
        mj_nxt       = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        mj_nxt       = mj_r + 3'd1;
        if (mj_r == 3'd7) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.rule) begin
          cmd.d6_start = 1'b1;
          state_nxt    = S_DIV6;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV6: begin
        if (st.d6_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free, then load it
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.n_zero) begin
            cmd.res_zero = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_div6 = st.rule;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pt_r    <= nii_pkg::PT_LO;
      step_r  <= '0;
      mj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pt_r    <= pt_nxt;
      step_r  <= step_nxt;
      mj_r    <= mj_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");
  a_pt_mid_rule: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval_acc && pt_r == nii_pkg::PT_MID |-> st.rule)
    else $error("midpoint evaluated under trapezoid rule");
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> $past(state_r) == S_MUL && $past(mj_r) == 3'd7)
    else $error("product finished early");
endmodule
`default_nettype wire

// File: rtl/core/numeric_interval_integrator.sv
// Top level of the numeric interval integrator.
// Computes the definite integral of x, 2x or sin x (integrand register) between two
// Q2.30 bounds over subinterval_count equal steps, by the trapezoid rule or Simpson's
// rule (rule register), and returns a saturated Q8.40 value; a zero count returns 0
// with count_error set. One request is worked at a time. A request is taken in and
// divided for the step, then per subinterval two point evaluations (three under
// Simpson) are made, each with CORDIC_STEPS rotations for the sine, the term is
// cleared and accumulated, then the product of sum and step is formed, under
// Simpson divided by six, and the result is loaded. The subinterval loop, with the
// sine CORDIC at one rotation a cycle, sets the rate. The result is loaded once the
// output register is free, and the next request is taken after that.
`default_nettype none
module numeric_interval_integrator #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned CORDIC_STEPS = 30
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  nii_in_if.sink                            in_ch,
  nii_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [nii_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [nii_pkg::CfgDataW-1:0] cfg_data
);
  nii_pkg::cmd_t cmd;
  nii_pkg::st_t  st;

  nii_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .cmd(cmd)
  );

  nii_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_start(in_ch.interval_start), .in_end(in_ch.interval_end),
    .in_count(in_ch.subinterval_count), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for numeric_interval_integrator: directed table plus random requests.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic RULE_TRAP = 1'b0;
  localparam logic RULE_SIMPSON = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000000;
  localparam logic signed [31:0] BOUND_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] BOUND_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [47:0] integral;
    logic               count_error;
  } integral_t;

  typedef struct {
    logic [1:0]         fn;
    logic               rule;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [15:0]        n;
    bit                 typed;
    logic signed [47:0] exp_integral;
    logic               exp_error;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [nii_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [nii_pkg::CfgDataW-1:0] cfg_data = '0;

  nii_in_if #(.COUNT_BITS(16)) in_if ();
  nii_out_if out_if ();

  numeric_interval_integrator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integral_t expected_q[$];
  logic [1:0] cur_fn = nii_pkg::FN_IDENT;
  logic cur_rule = RULE_TRAP;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int fail_cnt = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint atan_at(input int i);
    longint tbl[31] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 8, 4, 2, 1};
    return tbl[i];
  endfunction

  function automatic longint cordic_sine(input longint x);
    longint cx, cy, z, dx, dy;
    cx = nii_pkg::CORDIC_GAIN_Q30;
    cy = 0;
    z = x;
    if (z > nii_pkg::HALF_PI_Q30) z = nii_pkg::PI_Q30 - z;
    else if (z < -nii_pkg::HALF_PI_Q30) z = -nii_pkg::PI_Q30 - z;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(atan_at(i));
      end else begin
        cx += dx; cy -= dy; z += longint'(atan_at(i));
      end
    end
    return cy;
  endfunction

  function automatic longint eval_point(input longint pos, input logic [1:0] fn);
    longint x;
    x = pos >>> 16;
    case (fn)
      nii_pkg::FN_DOUBLE: return 2 * x;
      nii_pkg::FN_SINE:   return cordic_sine(x);
      default:            return x;
    endcase
  endfunction

  function automatic integral_t integrate(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic [15:0] n);
    integral_t res;
    longint h, pos, s, t, smax;
    logic [127:0] prod;
    logic [63:0] um, uh, mag;
    bit neg;
    smax = nii_pkg::SUM_MAX;
    res.count_error = 1'b0;
    if (n == 0) begin
      res.integral = '0;
      res.count_error = 1'b1;
      return res;
    end
    h = ((longint'(hi) - longint'(lo)) * 65536) / longint'({48'b0, n});
    pos = longint'(lo) * 65536;
    s = 0;
    for (int k = 0; k < n; k++) begin
      t = eval_point(pos, cur_fn) + eval_point(pos + h, cur_fn);
      if (cur_rule == RULE_SIMPSON) t += 4 * eval_point(pos + (h >>> 1), cur_fn);
      if (t > 0 && s > smax - t) s = smax;
      else if (t < 0 && s < -smax - t) s = -smax;
      else s = s + t;
      pos += h;
    end
    neg = (s < 0) != (h < 0);
    um = (s < 0) ? -s : s;
    uh = (h < 0) ? -h : h;
    prod = {64'b0, um} * {64'b0, uh};
    if (prod[127:84] != 0) begin
      res.integral = neg ? nii_pkg::RES_MIN : nii_pkg::RES_MAX;
    end else begin
      mag = prod[99:36];
      mag = (cur_rule == RULE_SIMPSON) ? (mag + 3) / 6 : (mag + 1) / 2;
      if (neg) res.integral = (mag > 64'h8000_0000_0000) ? nii_pkg::RES_MIN : -mag[47:0];
      else res.integral = (mag > 64'h7FFF_FFFF_FFFF) ? nii_pkg::RES_MAX : mag[47:0];
    end
    return res;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    integral_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result integral=%0d err=%0b",
                                  out_if.integral, out_if.count_error));
      end else begin
        want = expected_q.pop_front();
        if (out_if.integral !== want.integral)
          report_mismatch($sformatf("integral got %0d want %0d",
                                    out_if.integral, want.integral));
        if (out_if.count_error !== want.count_error)
          report_mismatch($sformatf("count_error got %0b want %0b",
                                    out_if.count_error, want.count_error));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 600;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_request(input logic signed [31:0] lo, input logic signed [31:0] hi,
                              input logic [15:0] n, input bit typed,
                              input logic signed [47:0] exp_integral,
                              input logic exp_error);
    integral_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.interval_start <= lo;
    in_if.interval_end <= hi;
    in_if.subinterval_count <= n;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    want = integrate(lo, hi, n);
    if (typed && (want.integral !== exp_integral || want.count_error !== exp_error))
      report_mismatch($sformatf("table row disagrees with predictor: %0d/%0b",
                                exp_integral, exp_error));
    if (typed) begin
      want.integral = exp_integral;
      want.count_error = exp_error;
    end
    expected_q.push_back(want);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write both registers; only called while the block is idle.
  task automatic set_config(input logic [1:0] fn, input logic rule);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= nii_pkg::CFG_INTEGRAND;
    cfg_data <= fn;
    @(posedge clk);
    cfg_index <= nii_pkg::CFG_RULE;
    cfg_data <= {1'b0, rule};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fn = fn;
    cur_rule = rule;
  endtask

  task automatic send_random();
    logic signed [31:0] lo, hi;
    logic [15:0] n;
    lo = $urandom;
    hi = $urandom;
    if ($urandom_range(3) == 0) begin
      lo = $signed(lo) >>> $urandom_range(20, 4);
      hi = $signed(hi) >>> $urandom_range(20, 4);
    end
    case ($urandom_range(9))
      0:       n = '0;
      1:       n = $urandom_range(300, 13);
      default: n = $urandom_range(12, 1);
    endcase
    send_request(lo, hi, n, 0, '0, 1'b0);
  endtask

  stim_row_t stim_table[] = '{
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    0, 0, 16'd0, 1, 48'sd0, 1'b1},
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    0, 0, 16'd1, 1, 48'sd0, 1'b0},
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    BOUND_MIN, BOUND_MAX, 16'd1, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    BOUND_MAX, BOUND_MIN, 16'd1, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    BOUND_MIN, BOUND_MAX, 16'd65535, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_IDENT,  RULE_TRAP,    32'sh4000_0000, 32'shC000_0000, 16'd7, 0,
      48'sd0, 1'b0},
    '{nii_pkg::FN_DOUBLE, RULE_TRAP,    BOUND_MIN, BOUND_MAX, 16'd3, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_DOUBLE, RULE_TRAP,    BOUND_MAX, BOUND_MIN, 16'd5, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_DOUBLE, RULE_TRAP,    5, 5, 16'd2, 1, 48'sd0, 1'b0},
    '{nii_pkg::FN_SINE,   RULE_TRAP,    BOUND_MIN, BOUND_MAX, 16'd8, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_SINE,   RULE_TRAP,    32'shC000_0000, 32'sh4000_0000, 16'd4, 0,
      48'sd0, 1'b0},
    '{nii_pkg::FN_SINE,   RULE_TRAP,    0, BOUND_MAX, 16'd0, 1, 48'sd0, 1'b1},
    '{nii_pkg::FN_SINE,   RULE_SIMPSON, BOUND_MIN, BOUND_MAX, 16'd16, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_SINE,   RULE_SIMPSON, 0, BOUND_MAX, 16'd2, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_SINE,   RULE_SIMPSON, 1, 1, 16'd0, 1, 48'sd0, 1'b1},
    '{nii_pkg::FN_IDENT,  RULE_SIMPSON, BOUND_MIN, BOUND_MAX, 16'd1, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_IDENT,  RULE_SIMPSON, 5, -5, 16'd3, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_DOUBLE, RULE_SIMPSON, BOUND_MIN, BOUND_MAX, 16'd255, 0, 48'sd0, 1'b0},
    '{nii_pkg::FN_DOUBLE, RULE_SIMPSON, BOUND_MAX, 0, 16'd6, 0, 48'sd0, 1'b0},
    // unused integrand code acts as the identity
    '{2'd3,               RULE_TRAP,    BOUND_MIN, BOUND_MAX, 16'd2, 0, 48'sd0, 1'b0},
    '{2'd3,               RULE_SIMPSON, 0, BOUND_MAX, 16'd0, 1, 48'sd0, 1'b1},
    '{2'd3,               RULE_SIMPSON, 32'shE000_0000, 32'sh3000_0000, 16'd9, 0,
      48'sd0, 1'b0}
  };

  int phase_idle[4] = '{0, 78, 0, 33};
  int phase_stall[4] = '{0, 0, 78, 33};

  initial begin
    in_if.valid = 1'b0;
    in_if.interval_start = '0;
    in_if.interval_end = '0;
    in_if.subinterval_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].fn != cur_fn || stim_table[i].rule != cur_rule)
        set_config(stim_table[i].fn, stim_table[i].rule);
      send_request(stim_table[i].lo, stim_table[i].hi, stim_table[i].n,
                   stim_table[i].typed, stim_table[i].exp_integral,
                   stim_table[i].exp_error);
    end

    // Hold the receiver off so the block backs up and stalls its input.
    set_config(nii_pkg::FN_IDENT, RULE_TRAP);
    hold_req = 1;
    repeat (6) send_request($urandom, $urandom, $urandom_range(4, 1), 0, '0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(3), $urandom_range(1));
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (14) send_random();
      set_config(ph[1:0] == 2'd3 ? nii_pkg::FN_SINE : ph[1:0], ph[0]);
      repeat (14) send_random();
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d results over all integrands and both rules,",
             requests_sent, results_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
